>>> src/pdf_pkg.sv
// Package for the packet deframer with CRC-32 check.
// Holds field widths, parser phase and result-kind encodings, and the result struct.
// No dependencies.
package pdf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CrcW    = 32;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CrcW-1:0]    CrcPoly   = 32'hEDB8_8320;
  localparam logic [CrcW-1:0]    CrcInit   = 32'hFFFF_FFFF;
  localparam logic [LenW-1:0]    MinLength = 16'd5;
  localparam logic [ByteW-1:0]   SyncFirstRst  = 8'h58;
  localparam logic [ByteW-1:0]   SyncSecondRst = 8'h78;

  localparam logic [CfgIdxW-1:0] RegSyncFirst  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegSyncSecond = 8'd1;

  typedef enum logic [3:0] {
    PH_SYNC0 = 4'd0,
    PH_SYNC1 = 4'd1,
    PH_LEN0  = 4'd2,
    PH_LEN1  = 4'd3,
    PH_CMD   = 4'd4,
    PH_DATA  = 4'd5,
    PH_CRC0  = 4'd6,
    PH_CRC1  = 4'd7,
    PH_CRC2  = 4'd8,
    PH_CRC3  = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] frame_command;
    logic [LenW-1:0]  payload_length;
  } result_t;

endpackage

>>> src/pdf_if.sv
// Channel interfaces for the packet deframer: received bytes, results, register writes.
// Depends on pdf_pkg.
interface pdf_in_if import pdf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdf_out_if import pdf_pkg::*;;
  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [ByteW-1:0] data_byte;
  logic [ByteW-1:0] frame_command;
  logic [LenW-1:0]  payload_length;

  modport source (output valid, output kind, output data_byte, output frame_command,
                  output payload_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_command,
                  input payload_length, output ready);
endinterface

interface pdf_cfg_if import pdf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] addr;
  logic [ByteW-1:0]   wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

>>> src/pdf_crc_byte.sv
// One-byte update of the reflected CRC-32 (8 bit steps, combinational).
// Depends on pdf_pkg.
module pdf_crc_byte import pdf_pkg::*; (
  input  logic [CrcW-1:0]  crc_i,
  input  logic [ByteW-1:0] byte_i,
  output logic [CrcW-1:0]  crc_o
);

  always_comb begin
    logic [CrcW-1:0] c;
    c = crc_i ^ {{(CrcW-ByteW){1'b0}}, byte_i};
    for (int i = 0; i < ByteW; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : '0);
    end
    crc_o = c;
  end

endmodule

>>> src/pdf_parser.sv
// Frame parser: sync hunt, length, command, payload and CRC fields, sync registers.
// Depends on pdf_pkg and pdf_crc_byte.
module pdf_parser import pdf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,
  input  logic [ByteW-1:0]   byte_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  output result_t            res_o
);

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  sync_first_q, sync_second_q;
  logic [LenW-1:0]   frame_len_q, frame_len_d;
  logic [LenW-1:0]   count_q, count_d, count_inc;
  logic [CrcW-1:0]   crc_q, crc_d, crc_seed, crc_next;
  logic [CrcW-1:0]   rx_crc_q, rx_crc_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic              first_hit, second_hit;

  assign first_hit  = (byte_i == sync_first_q);
  assign second_hit = (byte_i == sync_second_q);
  assign count_inc  = count_q + 16'd1;
  assign crc_seed   = (phase_q == PH_SYNC0) ? CrcInit : crc_q;

  pdf_crc_byte u_crc (
    .crc_i  (crc_seed),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  // Next phase
  always_comb begin
    phase_d = PH_SYNC0;
    case (phase_q)
      PH_SYNC0: phase_d = first_hit  ? PH_SYNC1 : PH_SYNC0;
      PH_SYNC1: phase_d = second_hit ? PH_LEN0  : PH_SYNC0;
      PH_LEN0:  phase_d = PH_LEN1;
      PH_LEN1:  phase_d = PH_CMD;
      PH_CMD:   phase_d = (MinLength >= frame_len_q) ? PH_CRC0 : PH_DATA;
      PH_DATA:  phase_d = (count_inc >= frame_len_q) ? PH_CRC0 : PH_DATA;
      PH_CRC0:  phase_d = PH_CRC1;
      PH_CRC1:  phase_d = PH_CRC2;
      PH_CRC2:  phase_d = PH_CRC3;
      PH_CRC3:  phase_d = PH_SYNC0;
      default:  phase_d = PH_SYNC0;
    endcase
  end

  // Datapath updates and result
  always_comb begin
    crc_d       = CrcInit;
    count_d     = '0;
    frame_len_d = frame_len_q;
    rx_crc_d    = rx_crc_q;
    cmd_d       = cmd_q;
    res_o       = '0;
    case (phase_q)
      PH_SYNC0: begin
        if (first_hit) begin
          crc_d   = crc_next;
          count_d = 16'd1;
        end
      end
      PH_SYNC1: begin
        if (second_hit) begin
          crc_d   = crc_next;
          count_d = 16'd2;
        end
      end
      PH_LEN0: begin
        crc_d       = crc_next;
        count_d     = 16'd3;
        frame_len_d = {byte_i, 8'h00};
      end
      PH_LEN1: begin
        crc_d       = crc_next;
        count_d     = 16'd4;
        frame_len_d = {frame_len_q[LenW-1:ByteW], byte_i};
      end
      PH_CMD: begin
        crc_d   = crc_next;
        count_d = MinLength;
        cmd_d   = byte_i;
      end
      PH_DATA: begin
        crc_d           = crc_next;
        count_d         = count_inc;
        res_o.valid     = 1'b1;
        res_o.kind      = KIND_DATA;
        res_o.data_byte = byte_i;
      end
      PH_CRC0: begin
        crc_d    = crc_q;
        count_d  = count_q;
        rx_crc_d = {byte_i, 24'h0};
      end
      PH_CRC1: begin
        crc_d    = crc_q;
        count_d  = count_q;
        rx_crc_d = {rx_crc_q[31:24], byte_i, 16'h0};
      end
      PH_CRC2: begin
        crc_d    = crc_q;
        count_d  = count_q;
        rx_crc_d = {rx_crc_q[31:16], byte_i, 8'h0};
      end
      PH_CRC3: begin
        rx_crc_d            = {rx_crc_q[31:8], byte_i};
        res_o.valid         = 1'b1;
        res_o.kind          = ((~crc_q) == {rx_crc_q[31:8], byte_i}) ? KIND_GOOD : KIND_BAD;
        res_o.frame_command = cmd_q;
        res_o.payload_length = (frame_len_q >= MinLength) ? (frame_len_q - MinLength) : '0;
      end
      default: ;
    endcase
    res_o.valid = res_o.valid & beat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC0;
      crc_q       <= CrcInit;
      count_q     <= '0;
      frame_len_q <= '0;
      rx_crc_q    <= '0;
      cmd_q       <= '0;
    end else if (beat_i) begin
      phase_q     <= phase_d;
      crc_q       <= crc_d;
      count_q     <= count_d;
      frame_len_q <= frame_len_d;
      rx_crc_q    <= rx_crc_d;
      cmd_q       <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == RegSyncFirst) begin
        sync_first_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == RegSyncSecond) begin
        sync_second_q <= cfg_wdata_i;
      end
    end
  end

endmodule

>>> src/pdf_out_stage.sv
// Result register between the parser and the output channel.
// Depends on pdf_pkg.
module pdf_out_stage import pdf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    beat_i,
  input  result_t res_i,
  input  logic    out_ready_i,
  output logic    in_ready_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t pay_q;

  // an incoming beat is only taken when the slot is free or draining
  assign in_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    if (beat_i) begin
      valid_d = res_i.valid;
    end else begin
      valid_d = valid_q & ~out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i && res_i.valid) begin
      pay_q <= res_i;
    end
  end

  always_comb begin
    res_o       = pay_q;
    res_o.valid = valid_q;
  end

endmodule

>>> src/packet_deframer_crc32_check.sv
// Throughput: one received byte per cycle unless the output stalls; the CRC-32 advances
// a byte in the same cycle. A result beat appears in the cycle after its input beat.
// The result register frees the input side whenever the output beat is taken.
// Reset (rst_ni low, asynchronous): parser hunts for the first sync byte, CRC at
// all ones, sync bytes back to 'X' and 'x', no result pending.
module packet_deframer_crc32_check import pdf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pdf_in_if.sink    rx_i,
  pdf_out_if.source tx_o,
  pdf_cfg_if.sink   cfg_i
);

  logic    rx_beat;
  logic    in_ready;
  result_t parse_res;
  result_t out_res;

  // Register writes are always taken and land at once; a new sync value
  // mid-frame only affects later sync checks.
  assign cfg_i.ready = 1'b1;

  assign rx_i.ready = in_ready;
  assign rx_beat    = rx_i.valid & in_ready;

  // Parser: phase, frame length, byte count, running CRC and received CRC.
  // It produces at most one result per byte, qualified by the beat.
  pdf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (rx_beat),
    .byte_i      (rx_i.rx_byte),
    .cfg_we_i    (cfg_i.valid),
    .cfg_addr_i  (cfg_i.addr),
    .cfg_wdata_i (cfg_i.wdata),
    .res_o       (parse_res)
  );

  // Result register: holds a beat under back-pressure while the parser keeps
  // taking bytes as soon as the slot drains.
  pdf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (rx_beat),
    .res_i       (parse_res),
    .out_ready_i (tx_o.ready),
    .in_ready_o  (in_ready),
    .res_o       (out_res)
  );

  assign tx_o.valid          = out_res.valid;
  assign tx_o.kind           = out_res.kind;
  assign tx_o.data_byte      = out_res.data_byte;
  assign tx_o.frame_command  = out_res.frame_command;
  assign tx_o.payload_length = out_res.payload_length;

endmodule

>>> src/pdf_checker.sv
// Port-level assertions for the packet deframer, bound to the top level.
// Depends on pdf_pkg.
module pdf_checker import pdf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [1:0]       kind_i,
  input logic [ByteW-1:0] data_byte_i,
  input logic [ByteW-1:0] frame_command_i,
  input logic [LenW-1:0]  payload_length_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped under back-pressure");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == KIND_DATA || kind_i == KIND_GOOD || kind_i == KIND_BAD))
    else $error("illegal result kind");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_DATA |-> frame_command_i == '0 && payload_length_i == '0)
    else $error("payload beat carries frame-end fields");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != KIND_DATA |-> data_byte_i == '0 && payload_length_i <= 16'd65530)
    else $error("frame-end beat malformed");

endmodule

bind packet_deframer_crc32_check pdf_checker u_pdf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (tx_o.valid),
  .out_ready_i      (tx_o.ready),
  .kind_i           (tx_o.kind),
  .data_byte_i      (tx_o.data_byte),
  .frame_command_i  (tx_o.frame_command),
  .payload_length_i (tx_o.payload_length)
);
